/* src/prq_pkg.sv */
// ----------------------------------------------------------------------------
// prq_pkg: shared types and codes of the priority ready queue
// Command and status codes, the beat structs of both channels, the token
// struct that travels along the row of level cells and the head-update struct.
// ----------------------------------------------------------------------------
package prq_pkg;

  localparam int IdW = 4;  // task id width, fixed by the command beat
  localparam int LvW = 4;  // level width, fixed by the command beat

  localparam logic [1:0] CMD_ENQ  = 2'd0;
  localparam logic [1:0] CMD_DEQ  = 2'd1;
  localparam logic [1:0] CMD_PEEK = 2'd2;
  localparam logic [1:0] CMD_NONE = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_DUP   = 2'd2;

  typedef struct packed {
    logic [1:0]     command;
    logic [IdW-1:0] task_id;
    logic [LvW-1:0] priority_req;
  } prq_in_t;

  typedef struct packed {
    logic [1:0]     status;
    logic [IdW-1:0] out_task_id;
    logic [LvW-1:0] out_priority;
  } prq_out_t;

  // token passed from cell to cell, one cell per cycle
  typedef struct packed {
    logic           valid;
    logic [1:0]     op;         // CMD_NONE for a rejected or unused command
    logic [IdW-1:0] task_id;    // task to append
    logic [LvW-1:0] level;      // target level on enqueue, found level on dequeue
    logic           found;
    logic [IdW-1:0] head;       // head task of the found level
    logic           last;       // found head is also the tail
    logic           link;       // enqueue hit a nonempty level
    logic [IdW-1:0] prev_tail;  // old tail that needs a successor link
  } prq_tok_t;

  // head rewrite after a dequeue that leaves the level nonempty
  typedef struct packed {
    logic           en;
    logic [LvW-1:0] level;
    logic [IdW-1:0] head;
  } prq_upd_t;

endpackage

/* src/priority_ready_queue.sv */
// ----------------------------------------------------------------------------
// priority_ready_queue: multilevel priority FIFO ready queue
// One FIFO of task ids per level, lower level more urgent; enqueue, dequeue
// of the most urgent head, and peek.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; busy then stays high
// until its result has been driven. Every command gives one result beat, shown
// for exactly one cycle with out_valid, and the receiver cannot hold it off.
// Each command sends a token down a row of min(NUM_LEVELS,16) level cells, one
// cell per cycle, and a dequeue that leaves its level nonempty then also passes
// through a read state that fetches the successor from the link memory. busy is
// already low during the result beat, so the next command can be taken at the
// edge that ends it. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module priority_ready_queue
  import prq_pkg::*;
#(
  parameter int NUM_TASKS  = 16,
  parameter int NUM_LEVELS = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  prq_in_t  in_data,
  output logic     out_valid,
  output prq_out_t out_data
);

  // ids and levels cannot go past the 4-bit fields
  localparam int NTE = (NUM_TASKS < 16) ? NUM_TASKS : 16;
  localparam int NLE = (NUM_LEVELS < 16) ? NUM_LEVELS : 16;
  localparam int TIW = $clog2(NTE);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_READ = 2'd2;

  logic [1:0]     state_r, state_nxt;
  prq_tok_t       launch_r, launch_nxt;
  logic [1:0]     st_r, st_nxt;
  logic [NTE-1:0] queued_r, queued_nxt;
  logic           out_valid_r, out_valid_nxt;
  prq_out_t       out_data_r, out_data_nxt;
  logic [LvW-1:0] hold_level_r, hold_level_nxt;
  logic [IdW-1:0] hold_head_r, hold_head_nxt;

  prq_tok_t       tok [NLE+1];
  logic [NLE:0]   tok_valids;
  prq_tok_t       ret;
  prq_upd_t       upd;

  logic [IdW-1:0] next_task [NTE];
  logic           mem_we;
  logic [TIW-1:0] mem_wa;
  logic [IdW-1:0] mem_rd_r;

  logic           accept;
  logic           tid_ok;
  logic           dup;
  logic [LvW-1:0] sat_level;

  assign accept    = start && (state_r == S_IDLE);
  assign tid_ok    = ({28'd0, in_data.task_id} < NUM_TASKS);
  assign dup       = tid_ok && queued_r[in_data.task_id[TIW-1:0]];
  assign sat_level = ({28'd0, in_data.priority_req} >= NUM_LEVELS)
                     ? LvW'(NUM_LEVELS - 1) : in_data.priority_req;
  assign ret       = tok[NLE];

  assign tok[0] = launch_r;

  for (genvar i = 0; i < NLE; i++) begin : g_cell
    prq_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cell_level (LvW'(i)),
      .tok_in     (tok[i]),
      .upd        (upd),
      .tok_out    (tok[i+1])
    );
  end

  for (genvar i = 0; i <= NLE; i++) begin : g_valid
    assign tok_valids[i] = tok[i].valid;
  end

  always_comb begin
    state_nxt      = state_r;
    launch_nxt     = launch_r;
    launch_nxt.valid = 1'b0;
    st_nxt         = st_r;
    queued_nxt     = queued_r;
    out_valid_nxt  = 1'b0;
    out_data_nxt   = '0;
    hold_level_nxt = hold_level_r;
    hold_head_nxt  = hold_head_r;
    mem_we         = 1'b0;
    mem_wa         = ret.prev_tail[TIW-1:0];
    upd            = '0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          launch_nxt.valid     = 1'b1;
          launch_nxt.op        = in_data.command;
          launch_nxt.task_id   = in_data.task_id;
          launch_nxt.level     = sat_level;
          launch_nxt.found     = 1'b0;
          launch_nxt.head      = '0;
          launch_nxt.last      = 1'b0;
          launch_nxt.link      = 1'b0;
          launch_nxt.prev_tail = '0;
          st_nxt               = ST_OK;
          if (in_data.command == CMD_ENQ && (!tid_ok || dup)) begin
            launch_nxt.op = CMD_NONE;
            st_nxt        = dup ? ST_DUP : ST_OK;
          end
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (ret.valid) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          case (ret.op) inside
            CMD_ENQ: begin
              queued_nxt[ret.task_id[TIW-1:0]] = 1'b1;
              mem_we = ret.link;
            end
            CMD_DEQ, CMD_PEEK: begin
              if (!ret.found) begin
                out_data_nxt.status = ST_EMPTY;
              end else begin
                out_data_nxt.out_task_id  = ret.head;
                out_data_nxt.out_priority = ret.level;
                if (ret.op == CMD_DEQ) begin
                  queued_nxt[ret.head[TIW-1:0]] = 1'b0;
                  if (!ret.last) begin
                    // successor comes out of the link memory next cycle
                    out_valid_nxt  = 1'b0;
                    hold_level_nxt = ret.level;
                    hold_head_nxt  = ret.head;
                    state_nxt      = S_READ;
                  end
                end
              end
            end
            default: begin
              out_data_nxt.status = st_r;
            end
          endcase
        end
      end
      S_READ: begin
        upd.en                    = 1'b1;
        upd.level                 = hold_level_r;
        upd.head                  = mem_rd_r;
        out_valid_nxt             = 1'b1;
        out_data_nxt.out_task_id  = hold_head_r;
        out_data_nxt.out_priority = hold_level_r;
        state_nxt                 = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // successor links, one entry per task
  always_ff @(posedge clk) begin
    if (mem_we) begin
      next_task[mem_wa] <= ret.task_id;
    end
    mem_rd_r <= next_task[ret.head[TIW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      launch_r.valid <= 1'b0;
      queued_r       <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      launch_r.valid <= launch_nxt.valid;
      queued_r       <= queued_nxt;
      out_valid_r    <= out_valid_nxt;
    end
    launch_r.op        <= launch_nxt.op;
    launch_r.task_id   <= launch_nxt.task_id;
    launch_r.level     <= launch_nxt.level;
    launch_r.found     <= launch_nxt.found;
    launch_r.head      <= launch_nxt.head;
    launch_r.last      <= launch_nxt.last;
    launch_r.link      <= launch_nxt.link;
    launch_r.prev_tail <= launch_nxt.prev_tail;
    st_r               <= st_nxt;
    out_data_r         <= out_data_nxt;
    hold_level_r       <= hold_level_nxt;
    hold_head_r        <= hold_head_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(tok_valids) <= 1)
    else $error("more than one token in the cell row");

  a_ret_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    ret.valid |-> state_r == S_SCAN)
    else $error("token returned outside of a scan");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy && !out_valid)
    else $error("accepted beat did not raise busy");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for two cycles");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status == ST_EMPTY)
      |-> (out_data.out_task_id == '0 && out_data.out_priority == '0))
    else $error("empty result carries a task");

endmodule

/* src/prq_cell.sv */
// ----------------------------------------------------------------------------
// prq_cell: one priority level of the ready queue
// Holds the head, tail and nonempty flag of its level FIFO. Appends, claims or
// peeks as the token passes by, and hands the token to the next cell each cycle.
// ----------------------------------------------------------------------------
module prq_cell
  import prq_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  input  logic [LvW-1:0] cell_level,
  input  prq_tok_t       tok_in,
  input  prq_upd_t       upd,
  output prq_tok_t       tok_out
);

  logic           nonempty_r, nonempty_nxt;
  logic [IdW-1:0] head_r, head_nxt;
  logic [IdW-1:0] tail_r, tail_nxt;
  prq_tok_t       tok_r, tok_nxt;

  always_comb begin
    nonempty_nxt = nonempty_r;
    head_nxt     = head_r;
    tail_nxt     = tail_r;
    tok_nxt      = tok_in;
    if (tok_in.valid) begin
      if (tok_in.op == CMD_ENQ && tok_in.level == cell_level) begin
        if (nonempty_r) begin
          tok_nxt.link      = 1'b1;
          tok_nxt.prev_tail = tail_r;
        end else begin
          head_nxt     = tok_in.task_id;
          nonempty_nxt = 1'b1;
        end
        tail_nxt = tok_in.task_id;
      end
      // first nonempty cell on the way wins
      if ((tok_in.op == CMD_DEQ || tok_in.op == CMD_PEEK) && !tok_in.found && nonempty_r) begin
        tok_nxt.found = 1'b1;
        tok_nxt.level = cell_level;
        tok_nxt.head  = head_r;
        tok_nxt.last  = (head_r == tail_r);
        if (tok_in.op == CMD_DEQ && head_r == tail_r) begin
          nonempty_nxt = 1'b0;
        end
      end
    end
    if (upd.en && upd.level == cell_level) begin
      head_nxt = upd.head;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nonempty_r  <= 1'b0;
      tok_r.valid <= 1'b0;
    end else begin
      nonempty_r  <= nonempty_nxt;
      tok_r.valid <= tok_nxt.valid;
    end
    head_r         <= head_nxt;
    tail_r         <= tail_nxt;
    tok_r.op        <= tok_nxt.op;
    tok_r.task_id   <= tok_nxt.task_id;
    tok_r.level     <= tok_nxt.level;
    tok_r.found     <= tok_nxt.found;
    tok_r.head      <= tok_nxt.head;
    tok_r.last      <= tok_nxt.last;
    tok_r.link      <= tok_nxt.link;
    tok_r.prev_tail <= tok_nxt.prev_tail;
  end

  assign tok_out = tok_r;

endmodule
